// ===== rtl/ldtw_pkg.sv =====
`timescale 1ns / 1ps

package ldtw_pkg;

  // payload widths
  localparam int ACTION_W  = 2;
  localparam int ADDR_W    = 3;
  localparam int SEG_W     = 8;
  localparam int LEVEL_W   = 3;
  localparam int HOLD_W    = 3;
  localparam int PHASE_W   = 7;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CONTROL = 2'd2;

  // command kinds
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_CONTROL = 1'b1;

  // command byte bases
  localparam logic [7:0] CMD_DATA_SET  = 8'h40;
  localparam logic [7:0] CMD_ADDR_SET  = 8'hC0;
  localparam logic [7:0] CMD_CTRL_BASE = 8'h80;
  localparam logic [7:0] CMD_CTRL_ON   = 8'h08;

  // frame layout
  localparam logic [PHASE_W-1:0] FRAME_A_LEN  = 7'd34;
  localparam logic [PHASE_W-1:0] START_LEN    = 7'd3;
  localparam logic [PHASE_W-1:0] BYTE_LEN     = 7'd27;
  localparam logic [4:0]         BITS_LEN     = 5'd24;

  // hold times in microseconds
  localparam logic [HOLD_W-1:0] HOLD_NONE  = 3'd0;
  localparam logic [HOLD_W-1:0] HOLD_SHORT = 3'd2;
  localparam logic [HOLD_W-1:0] HOLD_BIT   = 3'd3;
  localparam logic [HOLD_W-1:0] HOLD_ACK   = 3'd5;
  localparam logic [HOLD_W-1:0] HOLD_MAX   = 3'd5;

endpackage

// ===== rtl/ldtw_in_if.sv =====
`timescale 1ns / 1ps

interface ldtw_in_if;
  logic                         valid;
  logic                         ready;
  logic [ldtw_pkg::ACTION_W-1:0] action;
  logic [ldtw_pkg::ADDR_W-1:0]   digit_addr;
  logic [ldtw_pkg::SEG_W-1:0]    segment_bits;
  logic                         display_on;
  logic [ldtw_pkg::LEVEL_W-1:0]  bright_level;

  modport source (output valid, action, digit_addr, segment_bits, display_on,
                  bright_level, input ready);
  modport sink (input valid, action, digit_addr, segment_bits, display_on,
                bright_level, output ready);
endinterface

// ===== rtl/ldtw_out_if.sv =====
`timescale 1ns / 1ps

interface ldtw_out_if;
  logic                        valid;
  logic                        ready;
  logic                        clock_level;
  logic                        data_level;
  logic [ldtw_pkg::HOLD_W-1:0] hold_us;
  logic                        last_phase;

  modport source (output valid, clock_level, data_level, hold_us, last_phase,
                  input ready);
  modport sink (input valid, clock_level, data_level, hold_us, last_phase,
                output ready);
endinterface

// ===== rtl/led_display_two_wire_writer_unit.sv =====
`timescale 1ns / 1ps

// Two-wire LED display writer. A write or control transaction on in_ch latches
// its operands and starts a line sequence; each later tick transaction yields
// one line phase on out_ch (clock level, data level, hold time in us, and a
// last-phase flag). A control sequence is 34 ticks, a display write 95 ticks.
// Commands arriving while a sequence runs, and ticks while idle, are consumed
// with no result. One transaction is taken every cycle: a tick's phase is
// decoded in the same cycle and lands in the output register, so in_ch stalls
// only while that register holds a result that out_ch has not yet taken.
module led_display_two_wire_writer_unit (
  input  logic       clk,
  input  logic       rst_n,
  ldtw_in_if.sink    in_ch,
  ldtw_out_if.source out_ch
);

  // sequencer state
  logic [ldtw_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                         busy_r, busy_nxt;
  logic                         kind_r, kind_nxt;
  logic [ldtw_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ldtw_pkg::SEG_W-1:0]   seg_r, seg_nxt;
  logic [7:0]                   ctrl_r, ctrl_nxt;
  logic                         data_line_r, data_line_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_clk_r, out_clk_nxt;
  logic                        out_data_r, out_data_nxt;
  logic [ldtw_pkg::HOLD_W-1:0] out_hold_r, out_hold_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                         accept;
  logic                         frame_b;
  logic [ldtw_pkg::PHASE_W-1:0] p;
  logic [ldtw_pkg::PHASE_W-1:0] q;
  logic [ldtw_pkg::PHASE_W-1:0] region_len;
  logic [ldtw_pkg::PHASE_W-1:0] tail;
  logic                         second_byte;
  logic [4:0]                   r;
  logic [4:0]                   r_ack;
  logic [8:0]                   r_prod;
  logic [2:0]                   bit_pos;
  logic [4:0]                   sub;
  logic [7:0]                   cur_byte;
  logic                         clk_lvl;
  logic                         dl_new;
  logic [ldtw_pkg::HOLD_W-1:0]  hold;
  logic                         last;

  // handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // phase position inside the current frame
  always_comb begin
    frame_b    = (kind_r == ldtw_pkg::KIND_WRITE) && (phase_r >= ldtw_pkg::FRAME_A_LEN);
    p          = frame_b ? (phase_r - ldtw_pkg::FRAME_A_LEN) : phase_r;
    q          = p - ldtw_pkg::START_LEN;
    region_len = frame_b ? (ldtw_pkg::BYTE_LEN + ldtw_pkg::BYTE_LEN) : ldtw_pkg::BYTE_LEN;
    tail       = q - region_len;
    second_byte = (q >= ldtw_pkg::BYTE_LEN);
    r          = second_byte ? 5'(q - ldtw_pkg::BYTE_LEN) : q[4:0];
    r_ack      = r - ldtw_pkg::BITS_LEN;
    // r / 3 by reciprocal, exact for r below 24
    r_prod     = {4'd0, r} * 9'd11;
    bit_pos    = r_prod[7:5];
    sub        = r - 5'({2'd0, bit_pos} * 5'd3);
  end

  // byte on the wire
  always_comb begin
    if (kind_r == ldtw_pkg::KIND_CONTROL) begin
      cur_byte = ctrl_r;
    end else if (!frame_b) begin
      cur_byte = ldtw_pkg::CMD_DATA_SET + {5'd0, addr_r};
    end else if (!second_byte) begin
      cur_byte = ldtw_pkg::CMD_ADDR_SET + {5'd0, addr_r};
    end else begin
      cur_byte = seg_r;
    end
  end

  // line levels and hold for this phase
  always_comb begin
    clk_lvl = 1'b0;
    dl_new  = data_line_r;
    hold    = ldtw_pkg::HOLD_NONE;
    if (p < ldtw_pkg::START_LEN) begin
      clk_lvl = 1'b1;
      if (p == 7'd1) begin
        dl_new = 1'b1;
        hold   = ldtw_pkg::HOLD_SHORT;
      end else if (p == 7'd2) begin
        dl_new = 1'b0;
      end
    end else if (q < region_len) begin
      if (r < ldtw_pkg::BITS_LEN) begin
        if (sub == 5'd1) begin
          dl_new = cur_byte[bit_pos];
          hold   = ldtw_pkg::HOLD_BIT;
        end else if (sub == 5'd2) begin
          clk_lvl = 1'b1;
          hold    = ldtw_pkg::HOLD_BIT;
        end
      end else begin
        if (r_ack == 5'd0) begin
          hold = ldtw_pkg::HOLD_ACK;
        end else if (r_ack == 5'd1) begin
          clk_lvl = 1'b1;
          hold    = ldtw_pkg::HOLD_SHORT;
        end
      end
    end else begin
      if (tail == 7'd0) begin
        hold = ldtw_pkg::HOLD_SHORT;
      end else if (tail == 7'd1) begin
        dl_new = 1'b0;
        hold   = ldtw_pkg::HOLD_SHORT;
      end else if (tail == 7'd2) begin
        clk_lvl = 1'b1;
        hold    = ldtw_pkg::HOLD_SHORT;
      end else begin
        clk_lvl = 1'b1;
        dl_new  = 1'b1;
      end
    end
    last = (p == 7'd6 + region_len) && ((kind_r == ldtw_pkg::KIND_CONTROL) || frame_b);
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    busy_nxt      = busy_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    seg_nxt       = seg_r;
    ctrl_nxt      = ctrl_r;
    data_line_nxt = data_line_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_clk_nxt   = out_clk_r;
    out_data_nxt  = out_data_r;
    out_hold_nxt  = out_hold_r;
    out_last_nxt  = out_last_r;
    if (accept) begin
      case (in_ch.action)
        ldtw_pkg::ACT_WRITE, ldtw_pkg::ACT_CONTROL: begin
          if (!busy_r) begin
            busy_nxt  = 1'b1;
            phase_nxt = '0;
            kind_nxt  = (in_ch.action == ldtw_pkg::ACT_CONTROL) ?
                        ldtw_pkg::KIND_CONTROL : ldtw_pkg::KIND_WRITE;
            addr_nxt  = in_ch.digit_addr;
            seg_nxt   = in_ch.segment_bits;
            ctrl_nxt  = ldtw_pkg::CMD_CTRL_BASE
                        + (in_ch.display_on ? ldtw_pkg::CMD_CTRL_ON : 8'd0)
                        + {5'd0, in_ch.bright_level};
          end
        end
        ldtw_pkg::ACT_TICK: begin
          if (busy_r) begin
            data_line_nxt = dl_new;
            out_valid_nxt = 1'b1;
            out_clk_nxt   = clk_lvl;
            out_data_nxt  = dl_new;
            out_hold_nxt  = hold;
            out_last_nxt  = last;
            if (last) begin
              busy_nxt  = 1'b0;
              phase_nxt = '0;
            end else begin
              phase_nxt = phase_r + 7'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      busy_r      <= 1'b0;
      kind_r      <= ldtw_pkg::KIND_WRITE;
      addr_r      <= '0;
      seg_r       <= '0;
      ctrl_r      <= '0;
      data_line_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
      kind_r      <= kind_nxt;
      addr_r      <= addr_nxt;
      seg_r       <= seg_nxt;
      ctrl_r      <= ctrl_nxt;
      data_line_r <= data_line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_clk_r  <= out_clk_nxt;
    out_data_r <= out_data_nxt;
    out_hold_r <= out_hold_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.clock_level = out_clk_r;
  assign out_ch.data_level  = out_data_r;
  assign out_ch.hold_us     = out_hold_r;
  assign out_ch.last_phase  = out_last_r;

endmodule

// ===== rtl/ldtw_checker.sv =====
`timescale 1ns / 1ps

module ldtw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ldtw_pkg::ACTION_W-1:0] in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_clock_level,
  input logic                          out_data_level,
  input logic [ldtw_pkg::HOLD_W-1:0]   out_hold_us,
  input logic                          out_last_phase
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_clock_level)
      && $stable(out_data_level) && $stable(out_hold_us) && $stable(out_last_phase))
    else $error("stalled result changed");

  // a new result only follows an accepted tick
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_action == ldtw_pkg::ACT_TICK)))
    else $error("result without a tick");

  // commands never produce a result
  a_cmd_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action != ldtw_pkg::ACT_TICK) |=> !out_valid)
    else $error("result after a non-tick transaction");

  // final phase leaves both lines high with no hold
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_phase |-> out_clock_level && out_data_level
      && (out_hold_us == ldtw_pkg::HOLD_NONE))
    else $error("final phase does not release the lines");

endmodule

bind led_display_two_wire_writer_unit ldtw_checker u_ldtw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_action       (in_ch.action),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_clock_level (out_ch.clock_level),
  .out_data_level  (out_ch.data_level),
  .out_hold_us     (out_ch.hold_us),
  .out_last_phase  (out_ch.last_phase)
);

// ===== bench/led_display_two_wire_writer_unit_tb.sv =====
`timescale 1ns / 1ps

module led_display_two_wire_writer_unit_tb;

  // action code with no meaning, consumed by the block
  localparam logic [ldtw_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;

  // ticks per transaction: start, bytes with ack, stop
  localparam int CTRL_TICKS  = ldtw_pkg::START_LEN + ldtw_pkg::BYTE_LEN + 4;
  localparam int WRITE_TICKS = ldtw_pkg::FRAME_A_LEN + ldtw_pkg::START_LEN
                               + 2 * ldtw_pkg::BYTE_LEN + 4;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEM_TARGET  = 1300;

  typedef struct packed {
    logic [ldtw_pkg::ACTION_W-1:0] action;
    logic [ldtw_pkg::ADDR_W-1:0]   digit_addr;
    logic [ldtw_pkg::SEG_W-1:0]    segment_bits;
    logic                          display_on;
    logic [ldtw_pkg::LEVEL_W-1:0]  bright_level;
  } display_cmd_t;

  typedef struct packed {
    logic                        clock_level;
    logic                        data_level;
    logic [ldtw_pkg::HOLD_W-1:0] hold_us;
    logic                        last_phase;
  } line_phase_t;

  logic clk;
  logic rst_n;

  ldtw_in_if  in_ch ();
  ldtw_out_if out_ch ();

  led_display_two_wire_writer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  display_cmd_t pending_cmds[$];
  line_phase_t  expected_phases[$];

  int error_count = 0;
  int idle_cycles = 0;

  // handshake results of the last rising edge
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  // driver state
  display_cmd_t cur_cmd;
  logic         cmd_held = 1'b0;
  int           in_gap = 0;
  int           in_burst = 0;
  int           out_stall = 0;
  int           out_burst = 0;

  // predicted line sequencer state
  logic                         seq_busy;
  int                           seq_phase;
  logic                         seq_is_control;
  logic [ldtw_pkg::ADDR_W-1:0]  seq_addr;
  logic [ldtw_pkg::SEG_W-1:0]   seq_segments;
  logic [7:0]                   seq_control_byte;
  logic                         data_line_level;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // wait before the next transaction, with runs of back-to-back cycles
  function int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function void queue_cmd(logic [ldtw_pkg::ACTION_W-1:0] act,
                          logic [ldtw_pkg::ADDR_W-1:0] addr,
                          logic [ldtw_pkg::SEG_W-1:0] seg, logic on,
                          logic [ldtw_pkg::LEVEL_W-1:0] lvl);
    display_cmd_t c;
    c.action       = act;
    c.digit_addr   = addr;
    c.segment_bits = seg;
    c.display_on   = on;
    c.bright_level = lvl;
    pending_cmds.push_back(c);
  endfunction

  // command with random operands
  function void queue_random_operands(logic [ldtw_pkg::ACTION_W-1:0] act);
    queue_cmd(act, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
  endfunction

  // tick with random don't-care operands
  function void queue_tick();
    queue_random_operands(ldtw_pkg::ACT_TICK);
  endfunction

  // something the block ignores while a transaction runs
  function void queue_busy_noise();
    logic [ldtw_pkg::ACTION_W-1:0] act;
    case ($urandom_range(0, 2))
      0: act = ldtw_pkg::ACT_WRITE;
      1: act = ldtw_pkg::ACT_CONTROL;
      default: act = ACT_NONE;
    endcase
    queue_random_operands(act);
  endfunction

  // something the block ignores while idle
  function void queue_idle_noise();
    if ($urandom_range(0, 1) == 0) begin
      queue_tick();
    end else begin
      queue_random_operands(ACT_NONE);
    end
  endfunction

  // one whole transaction: command then every tick up to its last phase, with ignored noise among the ticks
  function void queue_transaction(logic is_control, logic [ldtw_pkg::ADDR_W-1:0] addr,
                                  logic [ldtw_pkg::SEG_W-1:0] seg, logic on,
                                  logic [ldtw_pkg::LEVEL_W-1:0] lvl, int noise_pct);
    int n;
    n = is_control ? CTRL_TICKS : WRITE_TICKS;
    queue_cmd(is_control ? ldtw_pkg::ACT_CONTROL : ldtw_pkg::ACT_WRITE, addr, seg, on, lvl);
    for (int i = 0; i < n; i++) begin
      if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) queue_busy_noise();
      queue_tick();
    end
  endfunction

  // line phase prediction for one accepted transaction
  task automatic predict_line_phase(input display_cmd_t c);
    int p, q, nbytes, bi, r, s;
    logic second;
    logic [7:0] tx_byte;
    line_phase_t ph;

    if (c.action == ldtw_pkg::ACT_WRITE || c.action == ldtw_pkg::ACT_CONTROL) begin
      if (!seq_busy) begin
        seq_busy         = 1'b1;
        seq_phase        = 0;
        seq_is_control   = (c.action == ldtw_pkg::ACT_CONTROL) ?
                           ldtw_pkg::KIND_CONTROL : ldtw_pkg::KIND_WRITE;
        seq_addr         = c.digit_addr;
        seq_segments     = c.segment_bits;
        seq_control_byte = ldtw_pkg::CMD_CTRL_BASE
                           + (c.display_on ? ldtw_pkg::CMD_CTRL_ON : 8'h00)
                           + 8'(c.bright_level);
      end
      return;
    end
    if (c.action != ldtw_pkg::ACT_TICK || !seq_busy) return;

    p = seq_phase;
    second = 1'b0;
    nbytes = 1;
    if (seq_is_control == ldtw_pkg::KIND_WRITE && p >= ldtw_pkg::FRAME_A_LEN) begin
      second = 1'b1;
      p -= ldtw_pkg::FRAME_A_LEN;
      nbytes = 2;
    end

    ph.clock_level = 1'b0;
    ph.hold_us     = ldtw_pkg::HOLD_NONE;
    if (p < ldtw_pkg::START_LEN) begin
      // start condition: data falls while clock is high
      ph.clock_level = 1'b1;
      if (p == 1) begin
        data_line_level = 1'b1;
        ph.hold_us = ldtw_pkg::HOLD_SHORT;
      end else if (p == 2) begin
        data_line_level = 1'b0;
      end
    end else begin
      q = p - ldtw_pkg::START_LEN;
      if (q < ldtw_pkg::BYTE_LEN * nbytes) begin
        bi = q / ldtw_pkg::BYTE_LEN;
        r  = q % ldtw_pkg::BYTE_LEN;
        if (seq_is_control == ldtw_pkg::KIND_CONTROL) tx_byte = seq_control_byte;
        else if (!second) tx_byte = ldtw_pkg::CMD_DATA_SET + 8'(seq_addr);
        else if (bi == 0) tx_byte = ldtw_pkg::CMD_ADDR_SET + 8'(seq_addr);
        else tx_byte = seq_segments;
        if (r < ldtw_pkg::BITS_LEN) begin
          // data bits, lsb first
          s = r % 3;
          if (s == 1) begin
            data_line_level = tx_byte[r / 3];
            ph.hold_us = ldtw_pkg::HOLD_BIT;
          end else if (s == 2) begin
            ph.clock_level = 1'b1;
            ph.hold_us = ldtw_pkg::HOLD_BIT;
          end
        end else begin
          // acknowledge clock, answer not sampled
          r -= ldtw_pkg::BITS_LEN;
          if (r == 0) begin
            ph.hold_us = ldtw_pkg::HOLD_ACK;
          end else if (r == 1) begin
            ph.clock_level = 1'b1;
            ph.hold_us = ldtw_pkg::HOLD_SHORT;
          end
        end
      end else begin
        // stop condition: data rises while clock is high
        s = q - ldtw_pkg::BYTE_LEN * nbytes;
        if (s == 0) begin
          ph.hold_us = ldtw_pkg::HOLD_SHORT;
        end else if (s == 1) begin
          data_line_level = 1'b0;
          ph.hold_us = ldtw_pkg::HOLD_SHORT;
        end else if (s == 2) begin
          ph.clock_level = 1'b1;
          ph.hold_us = ldtw_pkg::HOLD_SHORT;
        end else begin
          ph.clock_level = 1'b1;
          data_line_level = 1'b1;
        end
      end
    end

    ph.last_phase = (p == ldtw_pkg::START_LEN + ldtw_pkg::BYTE_LEN * nbytes + 3) &&
                    (seq_is_control == ldtw_pkg::KIND_CONTROL || second);
    if (ph.last_phase) begin
      seq_busy  = 1'b0;
      seq_phase = 0;
    end else begin
      seq_phase = (seq_phase + 1) % 128;
    end
    ph.data_level = data_line_level;
    expected_phases.push_back(ph);
  endtask

  // input driver, changes at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) cmd_held = 1'b0;
      if (!cmd_held) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd  = pending_cmds.pop_front();
          cmd_held = 1'b1;
          in_gap   = draw_wait(in_burst);
        end
      end
      in_ch.valid <= cmd_held;
      if (cmd_held) begin
        in_ch.action       <= cur_cmd.action;
        in_ch.digit_addr   <= cur_cmd.digit_addr;
        in_ch.segment_bits <= cur_cmd.segment_bits;
        in_ch.display_on   <= cur_cmd.display_on;
        in_ch.bright_level <= cur_cmd.bright_level;
      end

      // result side stalls
      if (out_fire) out_stall = draw_wait(out_burst);
      else if (out_stall > 0) out_stall--;
      out_ch.ready <= (out_stall == 0);
    end
  end

  // monitor, samples at the rising edge
  always @(posedge clk) begin
    line_phase_t exp_ph;
    display_cmd_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_phases.size() == 0) begin
          $error("line phase with no transaction pending");
          error_count++;
        end else begin
          exp_ph = expected_phases.pop_front();
          if (out_ch.clock_level !== exp_ph.clock_level) begin
            $error("clock_level expected %0d actual %0d",
                   exp_ph.clock_level, out_ch.clock_level);
            error_count++;
          end
          if (out_ch.data_level !== exp_ph.data_level) begin
            $error("data_level expected %0d actual %0d",
                   exp_ph.data_level, out_ch.data_level);
            error_count++;
          end
          if (out_ch.hold_us !== exp_ph.hold_us) begin
            $error("hold_us expected %0d actual %0d", exp_ph.hold_us, out_ch.hold_us);
            error_count++;
          end
          if (out_ch.last_phase !== exp_ph.last_phase) begin
            $error("last_phase expected %0d actual %0d",
                   exp_ph.last_phase, out_ch.last_phase);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.action       = in_ch.action;
        seen.digit_addr   = in_ch.digit_addr;
        seen.segment_bits = in_ch.segment_bits;
        seen.display_on   = in_ch.display_on;
        seen.bright_level = in_ch.bright_level;
        predict_line_phase(seen);
      end

      // watchdog on cycles without any transaction
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("led_display_two_wire_writer_unit_tb NOT OK");
          $finish;
        end
      end
    end
    in_fire  <= rst_n && in_ch.valid && in_ch.ready;
    out_fire <= rst_n && out_ch.valid && out_ch.ready;
  end

  // stimulus, reset and end of run
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.action       = ldtw_pkg::ACT_TICK;
    in_ch.digit_addr   = '0;
    in_ch.segment_bits = '0;
    in_ch.display_on   = 1'b0;
    in_ch.bright_level = '0;
    out_ch.ready       = 1'b0;
    rst_n              = 1'b0;

    seq_busy         = 1'b0;
    seq_phase        = 0;
    seq_is_control   = ldtw_pkg::KIND_WRITE;
    seq_addr         = '0;
    seq_segments     = '0;
    seq_control_byte = '0;
    data_line_level  = 1'b1;

    // directed: ignored items while idle, then extreme and patterned operands, then ignored items again
    queue_cmd(ldtw_pkg::ACT_TICK, 3'd7, 8'hFF, 1'b1, 3'd7);
    queue_cmd(ACT_NONE, 3'd0, 8'h00, 1'b0, 3'd0);
    queue_transaction(ldtw_pkg::KIND_CONTROL, 3'd0, 8'h00, 1'b0, 3'd0, 0);
    queue_transaction(ldtw_pkg::KIND_CONTROL, 3'd7, 8'hFF, 1'b1, 3'd7, 10);
    queue_transaction(ldtw_pkg::KIND_WRITE, 3'd0, 8'h00, 1'b0, 3'd0, 0);
    queue_transaction(ldtw_pkg::KIND_WRITE, 3'd7, 8'hFF, 1'b1, 3'd7, 5);
    queue_transaction(ldtw_pkg::KIND_WRITE, 3'd5, 8'hA5, 1'b0, 3'd3, 0);
    queue_transaction(ldtw_pkg::KIND_WRITE, 3'd6, 8'h5A, 1'b1, 3'd4, 0);
    queue_cmd(ldtw_pkg::ACT_TICK, 3'd2, 8'h3C, 1'b0, 3'd1);
    queue_cmd(ACT_NONE, 3'd7, 8'hFF, 1'b1, 3'd7);

    // random: mostly whole transactions, some idle noise
    while (pending_cmds.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) queue_idle_noise();
      end
      queue_transaction(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        3'($urandom_range(0, 7)), $urandom_range(0, 8));
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_cmds.size() != 0 || cmd_held || expected_phases.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_phases.size() != 0) begin
      $error("%0d line phases never arrived", expected_phases.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("led_display_two_wire_writer_unit_tb OK");
    end else begin
      $display("led_display_two_wire_writer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
